@@ rtl/gdq_pkg.sv @@
`timescale 1ns / 1ps

package gdq_pkg;

    // date field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int SERIAL_W = 22;
    localparam int DOY_W    = 9;

    // year range and month codes
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(y / 100) as (y * 5243) >> 19, exact for y below 43690
    localparam int RECIP_100_W   = 13;
    localparam int RECIP_SHIFT   = 19;
    localparam int PROD_W        = YEAR_W + RECIP_100_W;
    localparam int CENT_W        = 8;
    localparam logic [RECIP_100_W-1:0] RECIP_100 = 13'd5243;

    // weekday codes
    localparam logic [2:0] WD_FRIDAY   = 3'd5;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    // one query word
    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
        logic               include_end;
    } t_query;

    // one result word
    typedef struct packed {
        logic [2:0]          weekday;
        logic                week_last_day;
        logic                weekend;
        logic                business_day;
        logic [2:0]          days_left_week;
        logic [4:0]          days_left_month;
        logic [8:0]          days_left_year;
        logic [SERIAL_W-1:0] days_between;
        logic                bad_date;
    } t_result;

    // per-stage load enables of the date pipeline
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } t_stage_en;

    // days before the first of each month in a common year
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // length of a month, february by leap flag
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                 n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:              n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/gregorian_date_query_top.sv @@
`timescale 1ns / 1ps

// gregorian date query
// input channel: i_valid / o_ready carry a query word (start date, end date,
// include-end flag). output channel: o_valid / i_ready carry a result word
// (weekday and flags of the start date, days left in week, month and year,
// day count to the end date, bad-date flag).
// throughput: one word per cycle while the receiver takes results; five register
// stages (input, century split, calendar checks, serial day number, result) each
// take a new word every cycle unless held by a stall at the output.
// a stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and queries keep being accepted while a result waits at the output.
// when the receiver stalls, the pipeline fills; o_ready drops only once all
// five stages hold words, and the result stays unchanged until taken.
// a query with an impossible date in either field gives bad_date and zeros.
// reset clears every stage valid bit; no results are pending after reset.
module gregorian_date_query_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gdq_pkg::t_query i_query,
    output logic            o_valid,
    input  logic            i_ready,
    output gdq_pkg::t_result o_result
);

    // stage valid bits and enables
    logic r_v_in, r_v_a, r_v_b, r_v_c, r_v_out;
    logic en_in, en_out;
    gdq_pkg::t_stage_en stage_en;

    // payload registers
    gdq_pkg::t_query  r_in;
    logic             r_inc_a, r_inc_b, r_inc_c;
    gdq_pkg::t_result r_out;
    gdq_pkg::t_result n_out;

    // per-date results
    logic [gdq_pkg::SERIAL_W-1:0] start_serial, end_serial;
    logic                         start_ok, end_ok;
    logic [4:0]                   left_month;
    logic [8:0]                   left_year;

    // weekday fold
    logic [5:0] fold1;
    logic [3:0] fold2;
    logic [2:0] fold3;
    logic [2:0] wd;

    // stage enables, from the output back
    assign en_out         = !r_v_out || i_ready;
    assign stage_en.en_c  = !r_v_c || en_out;
    assign stage_en.en_b  = !r_v_b || stage_en.en_c;
    assign stage_en.en_a  = !r_v_a || stage_en.en_b;
    assign en_in          = !r_v_in || stage_en.en_a;
    assign o_ready        = en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_a   <= 1'b0;
            r_v_b   <= 1'b0;
            r_v_c   <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (en_in)         r_v_in  <= i_valid;
            if (stage_en.en_a) r_v_a   <= r_v_in;
            if (stage_en.en_b) r_v_b   <= r_v_a;
            if (stage_en.en_c) r_v_c   <= r_v_b;
            if (en_out)        r_v_out <= r_v_c;
        end
    end

    // input register and include flag delay line
    always_ff @(posedge i_clk) begin
        if (en_in)         r_in    <= i_query;
        if (stage_en.en_a) r_inc_a <= r_in.include_end;
        if (stage_en.en_b) r_inc_b <= r_inc_a;
        if (stage_en.en_c) r_inc_c <= r_inc_b;
    end

    gdq_day_number u_start (
        .i_clk        (i_clk),
        .i_en         (stage_en),
        .i_day        (r_in.start_day),
        .i_month      (r_in.start_month),
        .i_year       (r_in.start_year),
        .o_serial     (start_serial),
        .o_valid_date (start_ok),
        .o_left_month (left_month),
        .o_left_year  (left_year)
    );

    gdq_day_number u_end (
        .i_clk        (i_clk),
        .i_en         (stage_en),
        .i_day        (r_in.end_day),
        .i_month      (r_in.end_month),
        .i_year       (r_in.end_year),
        .o_serial     (end_serial),
        .o_valid_date (end_ok),
        .o_left_month (),
        .o_left_year  ()
    );

    // serial mod 7 by summing octal digits, day one is a monday
    always_comb begin
        fold1 = 6'(start_serial[2:0])   + 6'(start_serial[5:3])
              + 6'(start_serial[8:6])   + 6'(start_serial[11:9])
              + 6'(start_serial[14:12]) + 6'(start_serial[17:15])
              + 6'(start_serial[20:18]) + 6'(start_serial[21]);
        fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
        fold3 = 3'(fold2[3]) + fold2[2:0];
        wd    = (fold3 == 3'd7) ? 3'd0 : fold3;
    end

    // result word
    always_comb begin
        n_out = '0;
        if (!(start_ok && end_ok)) begin
            n_out.bad_date = 1'b1;
        end else begin
            n_out.weekday         = wd;
            n_out.week_last_day   = (wd == gdq_pkg::WD_SATURDAY);
            n_out.weekend         = (wd == gdq_pkg::WD_FRIDAY) || (wd == gdq_pkg::WD_SATURDAY);
            n_out.business_day    = !n_out.weekend;
            n_out.days_left_week  = 3'd6 - wd;
            n_out.days_left_month = left_month;
            n_out.days_left_year  = left_year;
            n_out.days_between    = ((start_serial < end_serial) ? end_serial - start_serial
                                                                 : '0)
                                  + gdq_pkg::SERIAL_W'(r_inc_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) r_out <= n_out;
    end

    assign o_valid  = r_v_out;
    assign o_result = r_out;

endmodule

@@ rtl/gdq_day_number.sv @@
`timescale 1ns / 1ps

// three-stage per-date unit: century split, calendar checks, serial day number
module gdq_day_number (
    input  logic                              i_clk,
    input  gdq_pkg::t_stage_en                i_en,
    input  logic [gdq_pkg::DAY_W-1:0]         i_day,
    input  logic [gdq_pkg::MONTH_W-1:0]       i_month,
    input  logic [gdq_pkg::YEAR_W-1:0]        i_year,
    output logic [gdq_pkg::SERIAL_W-1:0]      o_serial,
    output logic                              o_valid_date,
    output logic [4:0]                        o_left_month,
    output logic [8:0]                        o_left_year
);

    // stage a registers
    logic [gdq_pkg::DAY_W-1:0]   r_day_a;
    logic [gdq_pkg::MONTH_W-1:0] r_month_a;
    logic [gdq_pkg::YEAR_W-1:0]  r_year_a;
    logic [gdq_pkg::CENT_W-1:0]  r_cent_a;
    logic [gdq_pkg::PROD_W-1:0]  n_prod;

    // stage b registers
    logic [gdq_pkg::YEAR_W-1:0]  r_prev_b;
    logic [gdq_pkg::CENT_W-1:0]  r_prev_cent_b;
    logic [gdq_pkg::DOY_W-1:0]   r_doy_b;
    logic                        r_valid_b;
    logic [4:0]                  r_left_month_b;
    logic [8:0]                  r_left_year_b;

    // stage c registers
    logic [gdq_pkg::SERIAL_W-1:0] r_serial_c;
    logic                         r_valid_c;
    logic [4:0]                   r_left_month_c;
    logic [8:0]                   r_left_year_c;

    // stage b logic
    logic [6:0]                  n_rem;
    logic                        n_leap;
    logic [gdq_pkg::DAY_W-1:0]   n_dim;
    logic [gdq_pkg::DOY_W-1:0]   n_doy;
    logic                        n_valid;
    logic [gdq_pkg::CENT_W-1:0]  n_prev_cent;
    logic [8:0]                  n_year_len;

    // stage c logic
    logic [gdq_pkg::SERIAL_W-1:0] n_serial;

    // year / 100 by reciprocal multiply
    assign n_prod = gdq_pkg::PROD_W'(i_year) * gdq_pkg::PROD_W'(gdq_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_day_a   <= i_day;
            r_month_a <= i_month;
            r_year_a  <= i_year;
            r_cent_a  <= n_prod[gdq_pkg::RECIP_SHIFT +: gdq_pkg::CENT_W];
        end
    end

    // leap year, validity and day of year
    always_comb begin
        n_rem  = 7'(r_year_a - gdq_pkg::YEAR_W'(r_cent_a) * gdq_pkg::YEAR_W'(100));
        n_leap = (r_year_a[1:0] == 2'b00) && ((n_rem != 7'd0) || (r_cent_a[1:0] == 2'b00));
        n_dim  = gdq_pkg::month_len(r_month_a, n_leap);
        n_valid = (r_month_a >= gdq_pkg::MONTH_JAN) && (r_month_a <= gdq_pkg::MONTH_DEC)
               && (r_year_a != '0) && (r_year_a <= gdq_pkg::YEAR_MAX)
               && (r_day_a != '0) && (r_day_a <= n_dim);
        n_doy = gdq_pkg::days_before(r_month_a) + gdq_pkg::DOY_W'(r_day_a)
              + gdq_pkg::DOY_W'((r_month_a > gdq_pkg::MONTH_FEB) && n_leap);
        // centuries in year-1 drop by one on a century year
        n_prev_cent = (n_rem == 7'd0) ? r_cent_a - 8'd1 : r_cent_a;
        n_year_len  = n_leap ? 9'd366 : 9'd365;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_prev_b       <= r_year_a - 14'd1;
            r_prev_cent_b  <= n_prev_cent;
            r_doy_b        <= n_doy;
            r_valid_b      <= n_valid;
            r_left_month_b <= n_dim - r_day_a + 5'd1;
            r_left_year_b  <= n_year_len - n_doy + 9'd1;
        end
    end

    // serial day number, 0001-01-01 is day one
    assign n_serial = gdq_pkg::SERIAL_W'(r_prev_b) * gdq_pkg::SERIAL_W'(365)
                    + gdq_pkg::SERIAL_W'(r_prev_b >> 2)
                    - gdq_pkg::SERIAL_W'(r_prev_cent_b)
                    + gdq_pkg::SERIAL_W'(r_prev_cent_b >> 2)
                    + gdq_pkg::SERIAL_W'(r_doy_b);

    always_ff @(posedge i_clk) begin
        if (i_en.en_c) begin
            r_serial_c     <= n_serial;
            r_valid_c      <= r_valid_b;
            r_left_month_c <= r_left_month_b;
            r_left_year_c  <= r_left_year_b;
        end
    end

    assign o_serial     = r_serial_c;
    assign o_valid_date = r_valid_c;
    assign o_left_month = r_left_month_c;
    assign o_left_year  = r_left_year_c;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF_NS      = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_PER_PHASE = 225;
    localparam int DRAIN_CYCLES     = 12;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int NUM_PHASES       = 4;

    localparam logic [2:0] WD_MONDAY = 3'd1;

    // a row of the directed table: query plus an optional hand-written answer
    typedef struct {
        gdq_pkg::t_query  query;
        bit               typed;
        gdq_pkg::t_result answer;
    } t_stim_row;

    localparam gdq_pkg::t_result BAD_ANSWER = '{bad_date: 1'b1, default: '0};

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_ready = 1'b0;
    gdq_pkg::t_query  i_query = '0;
    logic             o_ready;
    logic             o_valid;
    gdq_pkg::t_result o_result;

    gdq_pkg::t_result pending_answers[$];
    t_stim_row        directed_rows[$];
    int               mismatches     = 0;
    int               cycle_count    = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;

    gregorian_date_query_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_query  (i_query),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // calendar arithmetic

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            2:            return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic bit date_in_range(input int unsigned d, input int unsigned m,
                                         input int unsigned y);
        if (m < gdq_pkg::MONTH_JAN || m > gdq_pkg::MONTH_DEC || y < 1
            || y > gdq_pkg::YEAR_MAX)
            return 1'b0;
        return d >= 1 && d <= month_days(m, y);
    endfunction

    // 1-based ordinal day within the year
    function automatic int unsigned day_of_year(input int unsigned d, input int unsigned m,
                                                input int unsigned y);
        int unsigned n;
        n = d;
        for (int k = 1; k < m; k++)
            n += month_days(k, y);
        return n;
    endfunction

    // running day count, 0001-01-01 is day 1 (a monday)
    function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400 + day_of_year(d, m, y);
    endfunction

    // expected result word for one query word
    function automatic gdq_pkg::t_result date_query_answer(input gdq_pkg::t_query q);
        gdq_pkg::t_result r;
        int unsigned      n_start;
        int unsigned      n_end;
        int unsigned      wd;
        int unsigned      year_len;
        int unsigned      span;
        r = '0;
        if (!date_in_range(q.start_day, q.start_month, q.start_year) ||
            !date_in_range(q.end_day, q.end_month, q.end_year)) begin
            r.bad_date = 1'b1;
            return r;
        end
        n_start  = day_number(q.start_day, q.start_month, q.start_year);
        n_end    = day_number(q.end_day, q.end_month, q.end_year);
        wd       = n_start % 7;
        year_len = is_leap_year(q.start_year) ? 366 : 365;
        span     = (n_start < n_end) ? n_end - n_start : 0;
        span    += q.include_end;

        r.weekday         = wd[2:0];
        r.week_last_day   = (wd == gdq_pkg::WD_SATURDAY);
        r.weekend         = (wd == gdq_pkg::WD_FRIDAY) || (wd == gdq_pkg::WD_SATURDAY);
        r.business_day    = !r.weekend;
        r.days_left_week  = 3'(6 - wd);
        r.days_left_month = 5'(month_days(q.start_month, q.start_year) - q.start_day + 1);
        r.days_left_year  = 9'(year_len - day_of_year(q.start_day, q.start_month,
                                                      q.start_year) + 1);
        r.days_between    = span[gdq_pkg::SERIAL_W-1:0];
        return r;
    endfunction

    // stimulus helpers

    function automatic gdq_pkg::t_query mk_query(input int unsigned sd, input int unsigned sm,
                                                 input int unsigned sy, input int unsigned ed,
                                                 input int unsigned em, input int unsigned ey,
                                                 input bit inc);
        gdq_pkg::t_query q;
        q.start_day   = sd[gdq_pkg::DAY_W-1:0];
        q.start_month = sm[gdq_pkg::MONTH_W-1:0];
        q.start_year  = sy[gdq_pkg::YEAR_W-1:0];
        q.end_day     = ed[gdq_pkg::DAY_W-1:0];
        q.end_month   = em[gdq_pkg::MONTH_W-1:0];
        q.end_year    = ey[gdq_pkg::YEAR_W-1:0];
        q.include_end = inc;
        return q;
    endfunction

    function automatic gdq_pkg::t_result mk_answer(input logic [2:0] wd, input bit last,
                                                   input bit wkend, input bit biz,
                                                   input int unsigned left_wk,
                                                   input int unsigned left_mon,
                                                   input int unsigned left_yr,
                                                   input int unsigned span);
        gdq_pkg::t_result r;
        r.weekday         = wd;
        r.week_last_day   = last;
        r.weekend         = wkend;
        r.business_day    = biz;
        r.days_left_week  = left_wk[2:0];
        r.days_left_month = left_mon[4:0];
        r.days_left_year  = left_yr[8:0];
        r.days_between    = span[gdq_pkg::SERIAL_W-1:0];
        r.bad_date        = 1'b0;
        return r;
    endfunction

    // years weighted toward the ends of the range and century turns
    function automatic int unsigned pick_year();
        case ($urandom_range(9))
            0:       return $urandom_range(1, 12);
            1:       return $urandom_range(9990, 9999);
            2, 3:    return 100 * $urandom_range(1, 99) + $urandom_range(0, 8) - 4;
            default: return $urandom_range(1, 9999);
        endcase
    endfunction

    function automatic int unsigned pick_day(input int unsigned m, input int unsigned y);
        case ($urandom_range(3))
            0:       return 1;
            1:       return month_days(m, y);
            default: return $urandom_range(1, month_days(m, y));
        endcase
    endfunction

    // impossible day: zero or past the month end
    function automatic int unsigned bad_day(input int unsigned m, input int unsigned y);
        int unsigned len;
        len = month_days(m, y);
        if (len == 31 || $urandom_range(1) == 0)
            return 0;
        return $urandom_range(len + 1, 31);
    endfunction

    function automatic int unsigned bad_month();
        int unsigned k;
        k = $urandom_range(3);
        return (k == 0) ? 0 : 12 + k;
    endfunction

    function automatic int unsigned bad_year();
        return $urandom_range(1) ? 0 : $urandom_range(10000, 16383);
    endfunction

    // mostly well-formed date pairs, some with one field broken, some raw noise
    function automatic gdq_pkg::t_query random_query();
        gdq_pkg::t_query q;
        logic [63:0]     raw;
        int unsigned     mode;
        int unsigned     sd, sm, sy, ed, em, ey;
        mode = $urandom_range(99);
        if (mode >= 85) begin
            raw = {$urandom, $urandom};
            q   = raw[$bits(gdq_pkg::t_query)-1:0];
            return q;
        end
        sy = pick_year();
        sm = $urandom_range(1, 12);
        sd = pick_day(sm, sy);
        case ($urandom_range(3))
            0: ey = sy;
            1: ey = (sy + $urandom_range(1, 3) > gdq_pkg::YEAR_MAX) ? gdq_pkg::YEAR_MAX
                                                                    : sy + $urandom_range(1, 3);
            default: ey = pick_year();
        endcase
        em = ($urandom_range(3) == 0) ? sm : $urandom_range(1, 12);
        ed = pick_day(em, ey);
        if (mode >= 70) begin
            case ($urandom_range(5))
                0: sd = bad_day(sm, sy);
                1: sm = bad_month();
                2: sy = bad_year();
                3: ed = bad_day(em, ey);
                4: em = bad_month();
                default: ey = bad_year();
            endcase
        end
        return mk_query(sd, sm, sy, ed, em, ey, $urandom_range(1));
    endfunction

    // present one query word and record its answer once it is taken
    task automatic send_word(input gdq_pkg::t_query q, input bit typed,
                             input gdq_pkg::t_result answer);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_query <= q;
        do @(posedge i_clk); while (!o_ready);
        pending_answers.push_back(typed ? answer : date_query_answer(q));
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // receiver: random stalls, compare every word taken
    always @(posedge i_clk) begin
        gdq_pkg::t_result exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_answers.size() == 0) begin
                    $error("result word with no query outstanding");
                    mismatches++;
                end else begin
                    exp_r = pending_answers.pop_front();
                    check_field("weekday", exp_r.weekday, o_result.weekday);
                    check_field("week_last_day", exp_r.week_last_day, o_result.week_last_day);
                    check_field("weekend", exp_r.weekend, o_result.weekend);
                    check_field("business_day", exp_r.business_day, o_result.business_day);
                    check_field("days_left_week", exp_r.days_left_week,
                                o_result.days_left_week);
                    check_field("days_left_month", exp_r.days_left_month,
                                o_result.days_left_month);
                    check_field("days_left_year", exp_r.days_left_year,
                                o_result.days_left_year);
                    check_field("days_between", exp_r.days_between, o_result.days_between);
                    check_field("bad_date", exp_r.bad_date, o_result.bad_date);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL gregorian_date_query_top");
            $finish;
        end
    end

    // main sequence
    initial begin
        int idle_by_phase[NUM_PHASES];
        int stall_by_phase[NUM_PHASES];
        idle_by_phase  = '{0, 68, 0, 34};
        stall_by_phase = '{0, 0, 68, 34};

        // full range both ways, leap rules, impossible fields, weekday flags
        directed_rows.push_back('{mk_query(1, 1, 1, 31, 12, 9999, 1), 1'b1,
                                  mk_answer(WD_MONDAY, 0, 0, 1, 5, 31, 365, 3652059)});
        directed_rows.push_back('{mk_query(31, 12, 9999, 1, 1, 1, 0), 1'b1,
                                  mk_answer(gdq_pkg::WD_FRIDAY, 0, 1, 0, 1, 1, 1, 0)});
        directed_rows.push_back('{mk_query(29, 2, 2000, 1, 3, 2000, 0), 1'b0, '0});
        directed_rows.push_back('{mk_query(29, 2, 1900, 1, 3, 1900, 0), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(29, 2, 2023, 1, 3, 2023, 1), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(29, 2, 2024, 31, 12, 2024, 1), 1'b0, '0});
        directed_rows.push_back('{mk_query(31, 4, 2024, 1, 5, 2024, 0), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(1, 0, 2024, 1, 5, 2024, 0), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(1, 13, 2024, 1, 5, 2024, 1), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(1, 5, 2024, 1, 15, 2024, 0), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(1, 1, 0, 1, 1, 1, 0), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(1, 1, 1, 1, 1, 10000, 1), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(31, 15, 16383, 31, 15, 16383, 1), 1'b1,
                                  BAD_ANSWER});
        directed_rows.push_back('{mk_query(0, 6, 2024, 1, 7, 2024, 0), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(1, 6, 2024, 0, 7, 2024, 0), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(1, 6, 2023, 31, 6, 2023, 1), 1'b1, BAD_ANSWER});
        directed_rows.push_back('{mk_query(15, 6, 2024, 15, 6, 2024, 0), 1'b0, '0});
        directed_rows.push_back('{mk_query(15, 6, 2024, 15, 6, 2024, 1), 1'b0, '0});
        directed_rows.push_back('{mk_query(14, 6, 2024, 16, 6, 2024, 0), 1'b0, '0});
        directed_rows.push_back('{mk_query(16, 6, 2024, 14, 6, 2024, 1), 1'b0, '0});
        directed_rows.push_back('{mk_query(31, 12, 1600, 1, 1, 1601, 0), 1'b0, '0});
        directed_rows.push_back('{mk_query(1, 3, 1700, 28, 2, 2100, 1), 1'b0, '0});
        directed_rows.push_back('{mk_query(31, 1, 2024, 29, 2, 2024, 1), 1'b0, '0});

        // reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = idle_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            if (ph == 0) begin
                foreach (directed_rows[i])
                    send_word(directed_rows[i].query, directed_rows[i].typed,
                              directed_rows[i].answer);
            end
            repeat (RANDOM_PER_PHASE)
                send_word(random_query(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        // drain
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS gregorian_date_query_top");
        else
            $display("FAIL gregorian_date_query_top");
        $finish;
    end

endmodule

@@ files.f @@
rtl/gdq_pkg.sv
rtl/gdq_day_number.sv
rtl/gregorian_date_query_top.sv
bench/tb_top.sv
